[hdl/hed_pkg.sv]
// Shared types, constants and the Hilbert tap table for the envelope detector.
// Depends on nothing; every other file in hdl imports it.
package hed_pkg;

   localparam int SAMPLE_W   = 16;   // RF sample width
   localparam int QUAD_W     = 18;   // quadrature result width
   localparam int ENV_W      = 17;   // envelope result width
   localparam int HIST_DEPTH = 30;   // past samples kept per block
   localparam int PTR_W      = 5;    // history address / count width
   localparam int TAP_PAIRS  = 15;   // nonzero (odd) taps
   localparam int TAP_IDX_W  = 4;
   localparam int TAP_W      = 16;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 34;
   localparam int FRAC_BITS  = 15;
   localparam int MAC_LAST   = TAP_PAIRS + 2;  // sequencer count with final sum
   localparam int CNT_W      = 5;
   localparam int RAD_W      = 36;   // radicand width, even
   localparam int ROOT_W     = RAD_W / 2;
   localparam int REM_W      = ROOT_W + 3;
   localparam int STEP_W     = 5;

   localparam logic [ENV_W-1:0] ENV_MAX = {ENV_W{1'b1}};

   typedef enum logic {
      MAC_IDLE,
      MAC_RUN
   } hed_mac_state_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_MUL,
      SQ_SUM,
      SQ_ITER,
      SQ_DONE
   } hed_sq_state_type;

   typedef struct packed {
      logic                       done;
      logic signed [QUAD_W-1:0]   quad;
      logic signed [SAMPLE_W-1:0] sample;
   } hed_mac_res_type;

   typedef struct packed {
      logic             valid;
      logic [ENV_W-1:0] env;
   } hed_env_res_type;

   // Odd taps k = 2*idx+1 of the Q1.15 Hilbert table; even taps are zero.
   function automatic logic signed [TAP_W-1:0] hed_tap(input logic [TAP_IDX_W-1:0] idx);
      logic signed [TAP_W-1:0] t;
      case (idx)
         4'd0:    t = -16'sd804;
         4'd1:    t = -16'sd896;
         4'd2:    t = -16'sd1019;
         4'd3:    t = -16'sd1188;
         4'd4:    t = -16'sd1441;
         4'd5:    t = -16'sd1862;
         4'd6:    t = -16'sd2687;
         4'd7:    t = -16'sd5297;
         4'd8:    t = -16'sd20861;
         4'd9:    t = 16'sd20861;
         4'd10:   t = 16'sd5297;
         4'd11:   t = 16'sd2687;
         4'd12:   t = 16'sd1862;
         4'd13:   t = 16'sd1441;
         4'd14:   t = 16'sd1188;
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

[hdl/hed_mac.sv]
// History memory with its write pointer and fill count, plus the shared MAC
// that forms the quadrature value. Depends on hed_pkg.
module hed_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [hed_pkg::SAMPLE_W-1:0] sample,
   input  logic                                block_start,
   output hed_pkg::hed_mac_res_type            res
);
   import hed_pkg::*;

   logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];

   hed_mac_state_type          state_ff, state_in;
   logic [CNT_W-1:0]           t_ff;
   logic [PTR_W-1:0]           wp_ff;
   logic [PTR_W-1:0]           cnt_ff;
   logic signed [SAMPLE_W-1:0] x_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic [TAP_IDX_W-1:0]       m1_ff;
   logic                       v1_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic                       v2_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic signed [QUAD_W-1:0]   q_ff;
   logic                       done_ff;

   logic                       start_go;
   logic                       issue_en;
   logic                       finish;
   logic [PTR_W-1:0]           back_dist;
   logic [PTR_W:0]             addr_wrap;
   logic [PTR_W-1:0]           rd_addr;
   logic                       take_tap;
   logic signed [ACC_W-1:0]    acc_sh;
   logic signed [QUAD_W-1:0]   q_sat;

   // distance back from the write pointer: 2*m+1
   assign back_dist = {t_ff[TAP_IDX_W-1:0], 1'b1};
   assign addr_wrap = {1'b0, wp_ff} + (PTR_W+1)'(HIST_DEPTH) - {1'b0, back_dist};
   assign rd_addr   = (wp_ff >= back_dist) ? (wp_ff - back_dist) : addr_wrap[PTR_W-1:0];
   assign take_tap  = v1_ff && ({m1_ff, 1'b1} <= cnt_ff);

   assign acc_sh = acc_ff >>> FRAC_BITS;
   always_comb begin
      if (acc_sh > ACC_W'(2**(QUAD_W-1) - 1)) begin
         q_sat = {1'b0, {(QUAD_W-1){1'b1}}};
      end else if (acc_sh < -ACC_W'(2**(QUAD_W-1))) begin
         q_sat = {1'b1, {(QUAD_W-1){1'b0}}};
      end else begin
         q_sat = acc_sh[QUAD_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MAC_IDLE: if (start) state_in = MAC_RUN;
         MAC_RUN:  if (t_ff == CNT_W'(MAC_LAST)) state_in = MAC_IDLE;
         default:  state_in = MAC_IDLE;
      endcase
   end

   always_comb begin
      start_go = (state_ff == MAC_IDLE) && start;
      issue_en = (state_ff == MAC_RUN) && (t_ff < CNT_W'(TAP_PAIRS));
      finish   = (state_ff == MAC_RUN) && (t_ff == CNT_W'(MAC_LAST));
   end

   // memory port: one registered read, one write
   always_ff @(posedge clock) begin
      if (issue_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
      if (finish) begin
         hist_mem[wp_ff] <= x_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MAC_IDLE;
         t_ff     <= '0;
         wp_ff    <= '0;
         cnt_ff   <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue_en;
         v2_ff    <= take_tap;
         done_ff  <= finish;
         if (start_go) begin
            t_ff <= '0;
         end else if (state_ff == MAC_RUN) begin
            t_ff <= t_ff + 1'b1;
         end
         if (start_go && block_start) begin
            cnt_ff <= '0;
         end else if (finish && (cnt_ff < PTR_W'(HIST_DEPTH))) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (finish) begin
            wp_ff <= (wp_ff == PTR_W'(HIST_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      m1_ff <= t_ff[TAP_IDX_W-1:0];
      if (take_tap) begin
         prod_ff <= hed_tap(m1_ff) * rd_data_ff;
      end else begin
         prod_ff <= '0;
      end
      if (start_go) begin
         x_ff   <= sample;
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (finish) begin
         q_ff <= q_sat;
      end
   end

   assign res = '{done: done_ff, quad: q_ff, sample: x_ff};

endmodule

[hdl/hed_isqrt.sv]
// Squares sample and quadrature, sums them and takes the floor root one
// result bit per cycle; holds the saturated envelope until taken. Depends on hed_pkg.
module hed_isqrt (
   input  logic                     clock,
   input  logic                     reset,
   input  hed_pkg::hed_mac_res_type mac_res,
   input  logic                     take,
   output hed_pkg::hed_env_res_type env_res
);
   import hed_pkg::*;

   hed_sq_state_type      state_ff, state_in;
   logic [SAMPLE_W:0]     ax_ff;
   logic [QUAD_W-1:0]     aq_ff;
   logic [2*SAMPLE_W+1:0] sx_ff;
   logic [2*QUAD_W-1:0]   sq_ff;
   logic [RAD_W-1:0]      rad_ff;
   logic [REM_W-1:0]      rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [STEP_W-1:0]     step_ff;

   logic [SAMPLE_W:0]     x_ext;
   logic [REM_W-1:0]      rem_try;
   logic [REM_W-1:0]      trial;
   logic                  last_step;

   assign x_ext     = {mac_res.sample[SAMPLE_W-1], mac_res.sample};
   assign rem_try   = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial     = REM_W'({root_ff, 2'b01});
   assign last_step = (step_ff == STEP_W'(ROOT_W - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SQ_IDLE: if (mac_res.done) state_in = SQ_MUL;
         SQ_MUL:  state_in = SQ_SUM;
         SQ_SUM:  state_in = SQ_ITER;
         SQ_ITER: if (last_step) state_in = SQ_DONE;
         SQ_DONE: if (take) state_in = SQ_IDLE;
         default: state_in = SQ_IDLE;
      endcase
   end

   always_comb begin
      env_res.valid = (state_ff == SQ_DONE);
      env_res.env   = (root_ff > ROOT_W'(ENV_MAX)) ? ENV_MAX : root_ff[ENV_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == SQ_SUM) begin
            step_ff <= '0;
         end else if (state_ff == SQ_ITER) begin
            step_ff <= step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == SQ_IDLE) && mac_res.done) begin
         ax_ff <= x_ext[SAMPLE_W] ? (~x_ext + 1'b1) : x_ext;
         aq_ff <= mac_res.quad[QUAD_W-1] ? (~mac_res.quad + 1'b1) : mac_res.quad;
      end
      if (state_ff == SQ_MUL) begin
         sx_ff <= ax_ff * ax_ff;
         sq_ff <= aq_ff * aq_ff;
      end
      if (state_ff == SQ_SUM) begin
         rad_ff  <= RAD_W'(sx_ff) + RAD_W'(sq_ff);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (state_ff == SQ_ITER) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_try >= trial) begin
            rem_ff  <= rem_try - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_try;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

endmodule

[hdl/hilbert_envelope_detector_top.sv]
// Top level of the Hilbert FIR envelope detector: stream ports, busy
// tracking and the output register. Depends on hed_pkg, hed_mac, hed_isqrt.
//
//   channel | dir | handshake         | contents
//   req     | in  | req_tvalid/tready | tdata: sample; tuser: block_start
//   rsp     | out | rsp_tvalid/tready | tdata: quadrature, envelope
//
// One word in flight: after accept, rsp_tvalid rises once the word has passed the MAC
// walk over the history memory, magnitude capture, square and sum, the 18-step root
// and the output register; the next word is not taken before the last one has moved on.
// Reset clears the fill count so the history reads as zero; the memory itself
// is not cleared. req_tready rises again once the result moves into the output
// register, so a stalled rsp side holds at most one word plus one in work.
module hilbert_envelope_detector_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // block_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [17:0] quadrature, [34:18] envelope, [39:35] zero
);
   import hed_pkg::*;

   hed_mac_res_type  mac_res;
   hed_env_res_type  env_res;

   logic             busy_ff;
   logic             rsp_valid_ff;
   logic [QUAD_W-1:0] rsp_quad_ff;
   logic [ENV_W-1:0] rsp_env_ff;

   logic             accept;
   logic             take;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   // move the finished word out once the output register is free
   assign take       = env_res.valid && (!rsp_valid_ff || rsp_tready);

   hed_mac u_mac (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .sample      (req_tdata[SAMPLE_W-1:0]),
      .block_start (req_tuser),
      .res         (mac_res)
   );

   hed_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .mac_res (mac_res),
      .take    (take),
      .env_res (env_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (take) begin
            busy_ff <= 1'b0;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload: hold while the word waits
   always_ff @(posedge clock) begin
      if (take) begin
         rsp_quad_ff <= mac_res.quad;
         rsp_env_ff  <= env_res.env;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_env_ff, rsp_quad_ff};

endmodule

[sim/hed_stream_checker.sv]
// Stream checker for the Hilbert envelope detector: watches both channels,
// predicts each result word and compares it field by field. Depends on hed_pkg.
module hed_stream_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // [15:0] sample
   input  logic        req_tuser,    // block_start
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,    // [17:0] quadrature, [34:18] envelope
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   import hed_pkg::*;

   localparam logic signed [47:0] QUAD_HI = 48'sd131071;
   localparam logic signed [47:0] QUAD_LO = -48'sd131072;
   localparam int                 TAP_NUM = HIST_DEPTH + 1;

   typedef struct packed {
      logic signed [QUAD_W-1:0] quad;
      logic [ENV_W-1:0]         env;
   } env_word_type;

   logic signed [SAMPLE_W-1:0] past_samples [HIST_DEPTH];
   int                         fill_count;
   env_word_type               expected_words [$];

   // Q1.15 Hilbert coefficient for delay k; even delays carry no weight.
   function automatic logic signed [15:0] hilbert_coef(input int k);
      logic signed [15:0] c;
      case (k)
         1:       c = -16'sd804;
         3:       c = -16'sd896;
         5:       c = -16'sd1019;
         7:       c = -16'sd1188;
         9:       c = -16'sd1441;
         11:      c = -16'sd1862;
         13:      c = -16'sd2687;
         15:      c = -16'sd5297;
         17:      c = -16'sd20861;
         19:      c = 16'sd20861;
         21:      c = 16'sd5297;
         23:      c = 16'sd2687;
         25:      c = 16'sd1862;
         27:      c = 16'sd1441;
         29:      c = 16'sd1188;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   function automatic logic [31:0] floor_root(input logic [63:0] radicand);
      logic [63:0] rem;
      logic [63:0] root;
      logic [63:0] probe;
      rem   = radicand;
      root  = '0;
      probe = 64'd1 << 62;
      while (probe > rem) probe = probe >> 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root[31:0];
   endfunction

   // Run one sample through the filter and root, then advance the history.
   function automatic env_word_type envelope_predict(input logic signed [15:0] x,
                                                     input logic start);
      logic signed [47:0] acc;
      logic signed [47:0] coef;
      logic signed [47:0] term;
      logic signed [47:0] q;
      logic [63:0]        ax;
      logic [63:0]        aq;
      logic [31:0]        root;
      env_word_type       w;
      if (start) fill_count = 0;
      coef = hilbert_coef(0);
      term = x;
      acc  = coef * term;
      for (int k = 1; k < TAP_NUM; k++) begin
         if (k <= fill_count) begin
            coef = hilbert_coef(k);
            term = past_samples[k-1];
            acc  = acc + coef * term;
         end
      end
      q = acc >>> FRAC_BITS;
      if (q > QUAD_HI) q = QUAD_HI;
      if (q < QUAD_LO) q = QUAD_LO;
      term = x;
      ax   = (term < 0) ? -term : term;
      aq   = (q < 0) ? -q : q;
      root = floor_root(ax * ax + aq * aq);
      w.quad = q[QUAD_W-1:0];
      w.env  = (root > 32'(ENV_MAX)) ? ENV_MAX : root[ENV_W-1:0];
      for (int k = HIST_DEPTH - 1; k > 0; k--) past_samples[k] = past_samples[k-1];
      past_samples[0] = x;
      if (fill_count < HIST_DEPTH) fill_count++;
      return w;
   endfunction

   always @(posedge clock) begin : watch
      env_word_type want;
      env_word_type got;
      if (reset) begin
         expected_words.delete();
         fill_count = 0;
         for (int i = 0; i < HIST_DEPTH; i++) past_samples[i] = '0;
         pending_count <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_words.push_back(envelope_predict(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            got.quad = rsp_tdata[17:0];
            got.env  = rsp_tdata[34:18];
            if (expected_words.size() == 0) begin
               $error("unexpected result word: quadrature %0d, envelope %0d",
                      got.quad, got.env);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               checked_count++;
               if (got.quad !== want.quad) begin
                  $error("quadrature mismatch: expected %0d, actual %0d",
                         want.quad, got.quad);
                  fail_count++;
               end
               if (got.env !== want.env) begin
                  $error("envelope mismatch: expected %0d, actual %0d",
                         want.env, got.env);
                  fail_count++;
               end
            end
         end
         pending_count <= expected_words.size();
      end
   end

endmodule

[sim/hilbert_envelope_detector_top_tb.sv]
// Testbench top for the Hilbert envelope detector: clock, reset, stimulus,
// receiver back-pressure and verdict. Depends on hed_pkg and hed_stream_checker.
module hilbert_envelope_detector_top_tb;
   import hed_pkg::*;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int RANDOM_WORDS = 500;
   localparam int LONG_HOLD    = 400;   // well beyond two words of latency
   localparam int TAIL_CYCLES  = 64;    // covers the latency of one word

   typedef enum int {
      RX_OPEN,
      RX_COIN,
      RX_PERIODIC,
      RX_RARE_STALL
   } rx_mode_type;

   typedef enum int {
      BLK_QUAD_MAX,
      BLK_SHORT,
      BLK_WIDE,
      BLK_QUIET,
      BLK_EXTREME
   } blk_kind_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] sample
   logic        req_tuser;    // block_start
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [17:0] quadrature, [34:18] envelope, [39:35] zero

   int   fail_count;
   int   pending_count;
   int   checked_count;
   int   cycle_count;
   int   words_sent;
   int   starts_sent;
   int   burst_left;
   logic long_hold_go;
   logic long_hold_done;

   hilbert_envelope_detector_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hed_stream_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Bound the run; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d result words outstanding",
                  cycle_count, pending_count);
         $display("** hilbert_envelope_detector_top: FAILED **");
         $finish;
      end
   end

   // Offer one word and hold it until the block takes it. Bursts of random
   // length are separated by random gaps; a zero gap chains bursts back to back.
   task automatic send_word(input logic [15:0] word_data, input logic start);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            // drop valid and scramble the payload while idle
            @(negedge clock);
            req_tvalid <= 1'b0;
            req_tdata  <= 16'($urandom);
            req_tuser  <= 1'($urandom);
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= word_data;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      words_sent++;
      if (start) starts_sent++;
   endtask

   // Stop offering and hold until every expected result word has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [15:0] pick_sample(input blk_kind_type kind);
      int v;
      case (kind)
         BLK_QUIET: begin
            v = int'($urandom_range(0, 510)) - 255;
            return 16'(v);
         end
         BLK_EXTREME: begin
            case ($urandom_range(0, 4))
               0:       return 16'h7fff;
               1:       return 16'h8000;
               2:       return 16'h0000;
               3:       return 16'hffff;
               default: return 16'h0001;
            endcase
         end
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: hold tready per segment on a pattern of its own; once asked,
   // hold off completely for a long stretch so the block backs up.
   initial begin : receiver
      int          seg_len;
      int          period;
      rx_mode_type mode;
      rsp_tready     = 1'b0;
      long_hold_done = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (long_hold_go && !long_hold_done) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            long_hold_done = 1'b1;
         end
         seg_len = $urandom_range(20, 200);
         period  = $urandom_range(2, 8);
         mode    = rx_mode_type'($urandom_range(0, 3));
         for (int c = 0; c < seg_len; c++) begin
            @(negedge clock);
            case (mode)
               RX_OPEN:     rsp_tready <= 1'b1;
               RX_COIN:     rsp_tready <= 1'($urandom);
               RX_PERIODIC: rsp_tready <= ((c % period) == 0);
               default:     rsp_tready <= ($urandom_range(0, 15) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      logic [15:0]  s;
      blk_kind_type kind;
      int           len;
      int           random_words;
      logic         polarity;
      logic         paused;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      long_hold_go = 1'b0;
      burst_left   = 0;
      random_words = 0;
      paused       = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, bit patterns, restarts on a live history,
      // back-to-back block starts and a short impulse walk along the taps.
      send_word(16'h7fff, 1'b1);
      send_word(16'h8000, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h7fff, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h0001, 1'b0);
      send_word(16'hffff, 1'b0);
      send_word(16'h5555, 1'b0);
      send_word(16'haaaa, 1'b0);
      send_word(16'h7fff, 1'b1);
      send_word(16'h8000, 1'b1);
      send_word(16'h0000, 1'b1);
      send_word(16'h7fff, 1'b1);
      repeat (5) send_word(16'h0000, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'h0001, 1'b1);
      send_word(16'hffff, 1'b0);
      wait_drained();

      // Ask the receiver for its long hold-off while words keep coming.
      long_hold_go = 1'b1;

      while (random_words < RANDOM_WORDS) begin
         if (!paused && random_words >= RANDOM_WORDS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1:    kind = BLK_QUAD_MAX;
            2:       kind = BLK_SHORT;
            3, 4:    kind = BLK_QUIET;
            5:       kind = BLK_EXTREME;
            default: kind = BLK_WIDE;
         endcase
         if (kind == BLK_QUAD_MAX) begin
            // Full block whose odd delays line up with the tap signs, driving
            // the quadrature to its largest magnitude of either sign.
            polarity = 1'($urandom);
            for (int j = 0; j <= HIST_DEPTH; j++) begin
               if (j % 2 == 1)
                  s = ((j <= 11) ^ polarity) ? 16'h7fff : 16'h8000;
               else
                  s = 16'($urandom);
               send_word(s, j == 0);
               random_words++;
            end
         end else begin
            len = (kind == BLK_SHORT) ? $urandom_range(1, 4) : $urandom_range(5, 60);
            for (int i = 0; i < len; i++) begin
               // a stray restart now and then breaks the block mid-way
               send_word(pick_sample(kind), (i == 0) || ($urandom_range(0, 39) == 0));
               random_words++;
            end
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run: %0d words sent in %0d blocks, %0d result words compared.",
               words_sent, starts_sent, checked_count);
      $display("Covered sample extremes, peak quadrature blocks, restarts, long stall.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("** hilbert_envelope_detector_top: PASSED **");
      end else begin
         $display("** hilbert_envelope_detector_top: FAILED **");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/hed_pkg.sv
hdl/hed_mac.sv
hdl/hed_isqrt.sv
hdl/hilbert_envelope_detector_top.sv
sim/hed_stream_checker.sv
sim/hilbert_envelope_detector_top_tb.sv
